// ----- hdl/hba_pkg.sv -----
package hba_pkg;

    localparam int LEVEL_W    = 6;
    localparam int FANOUT     = 64;
    localparam int WORD_W     = 2 * LEVEL_W;
    localparam int SLOT_W     = 3 * LEVEL_W;
    localparam int LEAF_DEPTH = FANOUT * FANOUT;
    localparam int SLOT_SPACE = 1 << SLOT_W;
    localparam int SLOT_COUNT = 262144;

    // usable slots, capped at what the store can hold
    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_COUNT > SLOT_SPACE) ?
        (SLOT_W + 1)'(SLOT_SPACE) : (SLOT_W + 1)'(SLOT_COUNT);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef logic [FANOUT-1:0]  map_word_t;
    typedef logic [LEVEL_W-1:0] lvl_idx_t;
    typedef logic [WORD_W-1:0]  word_idx_t;
    typedef logic [SLOT_W-1:0]  slot_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_MID,
        S_LEAF,
        S_FREE_RD,
        S_FREE_UPD,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        FZ_ROOT,
        FZ_MID,
        FZ_LEAF
    } fz_src_t;

    typedef struct packed {
        logic    ready;
        fz_src_t fz_src;
        logic    root_step;
        logic    mid_step;
        logic    leaf_step;
        logic    free_rd;
        logic    free_upd;
        logic    clear_wr;
        logic    out_load;
    } ctrl_t;

    typedef struct packed {
        logic req_valid;
        logic req_kind;
        logic fz_none;
        logic clear_last;
        logic out_free;
    } stat_t;

endpackage

// ----- hdl/hba_req_if.sv -----
interface hba_req_if;
    import hba_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    slot_t slot_index;

    modport source (output valid, kind, slot_index, input ready);
    modport sink   (input valid, kind, slot_index, output ready);
endinterface

// ----- hdl/hba_rsp_if.sv -----
interface hba_rsp_if;
    import hba_pkg::*;

    logic       valid;
    logic       ready;
    slot_t      granted_index;
    logic [1:0] status;

    modport source (output valid, granted_index, status, input ready);
    modport sink   (input valid, granted_index, status, output ready);
endinterface

// ----- hdl/hba_first_zero.sv -----
module hba_first_zero (
    input  hba_pkg::map_word_t word,
    output hba_pkg::lvl_idx_t  idx,
    output logic               none
);
    import hba_pkg::*;

    logic [63:0] z0;
    logic [31:0] z1;
    logic [15:0] z2;
    logic [7:0]  z3;
    logic [3:0]  z4;
    logic [1:0]  z5;

    // binary halving on the inverted word
    always_comb
    begin
        z0     = ~word;
        none   = (z0 == '0);
        idx[5] = (z0[31:0] == '0);
        z1     = idx[5] ? z0[63:32] : z0[31:0];
        idx[4] = (z1[15:0] == '0);
        z2     = idx[4] ? z1[31:16] : z1[15:0];
        idx[3] = (z2[7:0] == '0);
        z3     = idx[3] ? z2[15:8] : z2[7:0];
        idx[2] = (z3[3:0] == '0);
        z4     = idx[2] ? z3[7:4] : z3[3:0];
        idx[1] = (z4[1:0] == '0);
        z5     = idx[1] ? z4[3:2] : z4[1:0];
        idx[0] = ~z5[0];
    end
endmodule

// ----- hdl/hba_seq.sv -----
module hba_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  hba_pkg::stat_t stat,
    output hba_pkg::ctrl_t ctrl
);
    import hba_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (stat.clear_last)
                    state_next = S_IDLE;
            S_IDLE:
                if (stat.req_valid)
                    state_next = (stat.req_kind == KIND_FREE) ? S_FREE_RD : S_ROOT;
            S_ROOT:
                state_next = stat.fz_none ? S_DONE : S_MID;
            S_MID:
                state_next = stat.fz_none ? S_DONE : S_LEAF;
            S_LEAF:
                state_next = S_DONE;
            S_FREE_RD:
                state_next = S_FREE_UPD;
            S_FREE_UPD:
                state_next = S_DONE;
            S_DONE:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        ctrl           = '0;
        ctrl.fz_src    = FZ_LEAF;
        unique case (state_reg)
            S_CLEAR:    ctrl.clear_wr = 1'b1;
            S_IDLE:     ctrl.ready    = 1'b1;
            S_ROOT:
            begin
                ctrl.fz_src    = FZ_ROOT;
                ctrl.root_step = 1'b1;
            end
            S_MID:
            begin
                ctrl.fz_src   = FZ_MID;
                ctrl.mid_step = 1'b1;
            end
            S_LEAF:     ctrl.leaf_step = 1'b1;
            S_FREE_RD:  ctrl.free_rd   = 1'b1;
            S_FREE_UPD: ctrl.free_upd  = 1'b1;
            S_DONE:     ctrl.out_load  = stat.out_free;
            default:    ctrl.clear_wr  = 1'b0;
        endcase
    end
endmodule

// ----- hdl/hierarchical_bitmap_allocator.sv -----
// Hierarchical bitmap slot allocator, three 64-ary levels over 262144 slots.
// Allocate: the walk visits the root, middle and leaf levels, then the result loads;
// it ends early when the root or middle summary is full. Free: read, update, then load.
// One transaction at a time; the next request is accepted once the result has loaded,
// and the load waits while the output register still holds an unaccepted response.
// Reset: async, active low; then a clearing pass clears the bitmaps, req.ready low.
module hierarchical_bitmap_allocator (
    input logic       clk,
    input logic       rst_n,
    hba_req_if.sink   req,
    hba_rsp_if.source rsp
);
    import hba_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // Storage: root summary in flops, middle summaries and leaf words in RAM.
    map_word_t root_reg;
    map_word_t mid_mem  [FANOUT];
    map_word_t leaf_mem [LEAF_DEPTH];
    map_word_t mid_rd_reg;
    map_word_t leaf_rd_reg;

    // Walk state and latched request
    slot_t     slot_reg;
    lvl_idx_t  r_reg;
    lvl_idx_t  m_reg;
    word_idx_t clr_cnt_reg;

    // Result held between commit and the output register
    slot_t     res_granted_reg;
    status_t   res_status_reg;
    logic      out_valid_reg;
    slot_t     out_granted_reg;
    status_t   out_status_reg;

    // Shared first-zero unit, fed by whichever level is being visited
    map_word_t fz_word;
    lvl_idx_t  fz_idx;
    logic      fz_none;

    always_comb
    begin
        case (ctrl.fz_src)
            FZ_ROOT: fz_word = root_reg;
            FZ_MID:  fz_word = mid_rd_reg;
            default: fz_word = leaf_rd_reg;
        endcase
    end

    hba_first_zero u_fz (
        .word (fz_word),
        .idx  (fz_idx),
        .none (fz_none)
    );

    // Allocate path: candidate slot and summary propagation
    logic [SLOT_W:0] alloc_slot;
    logic            alloc_over;
    map_word_t       leaf_set;
    map_word_t       mid_set;
    logic            alloc_ok;
    logic            alloc_commit;

    // Free path: field split of the latched slot
    lvl_idx_t        free_l;
    word_idx_t       free_w;
    lvl_idx_t        free_r;
    logic            free_bad;
    logic            free_commit;

    always_comb
    begin
        alloc_slot   = {1'b0, r_reg, m_reg, fz_idx};
        alloc_over   = (alloc_slot >= SLOT_LIMIT);
        leaf_set     = leaf_rd_reg | (map_word_t'(1) << fz_idx);
        mid_set      = mid_rd_reg | (map_word_t'(1) << m_reg);
        alloc_ok     = !fz_none && !alloc_over;
        alloc_commit = ctrl.leaf_step && alloc_ok;

        free_l       = slot_reg[LEVEL_W-1:0];
        free_w       = slot_reg[SLOT_W-1:LEVEL_W];
        free_r       = slot_reg[SLOT_W-1:WORD_W];
        free_bad     = ({1'b0, slot_reg} >= SLOT_LIMIT) || !leaf_rd_reg[free_l];
        free_commit  = ctrl.free_upd && !free_bad;
    end

    // RAM port steering
    logic      leaf_we;
    word_idx_t leaf_waddr;
    map_word_t leaf_wdata;
    logic      leaf_re;
    word_idx_t leaf_raddr;
    logic      mid_we;
    lvl_idx_t  mid_waddr;
    map_word_t mid_wdata;
    logic      mid_re;
    lvl_idx_t  mid_raddr;

    always_comb
    begin
        leaf_we    = 1'b0;
        leaf_waddr = clr_cnt_reg;
        leaf_wdata = '0;
        mid_we     = 1'b0;
        mid_waddr  = clr_cnt_reg[LEVEL_W-1:0];
        mid_wdata  = '0;
        if (ctrl.clear_wr)
        begin
            // middle RAM is zeroed too; its words are rewritten repeatedly during the pass
            leaf_we = 1'b1;
            mid_we  = 1'b1;
        end
        else if (alloc_commit)
        begin
            leaf_we    = 1'b1;
            leaf_waddr = {r_reg, m_reg};
            leaf_wdata = leaf_set;
            mid_we     = &leaf_set;
            mid_waddr  = r_reg;
            mid_wdata  = mid_set;
        end
        else if (free_commit)
        begin
            // child words can no longer be full: clear both summaries
            leaf_we    = 1'b1;
            leaf_waddr = free_w;
            leaf_wdata = leaf_rd_reg & ~(map_word_t'(1) << free_l);
            mid_we     = 1'b1;
            mid_waddr  = free_r;
            mid_wdata  = mid_rd_reg & ~(map_word_t'(1) << free_w[LEVEL_W-1:0]);
        end

        leaf_re    = ctrl.mid_step || ctrl.free_rd;
        leaf_raddr = ctrl.free_rd ? free_w : {r_reg, fz_idx};
        mid_re     = ctrl.root_step || ctrl.free_rd;
        mid_raddr  = ctrl.free_rd ? free_r : fz_idx;
    end

    always_ff @(posedge clk)
    begin
        if (leaf_we)
            leaf_mem[leaf_waddr] <= leaf_wdata;
        if (leaf_re)
            leaf_rd_reg <= leaf_mem[leaf_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mid_we)
            mid_mem[mid_waddr] <= mid_wdata;
        if (mid_re)
            mid_rd_reg <= mid_mem[mid_raddr];
    end

    // Root summary: set when the middle word fills, cleared on any good free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root_reg <= '0;
        else if (alloc_commit && (&leaf_set) && (&mid_set))
            root_reg <= root_reg | (map_word_t'(1) << r_reg);
        else if (free_commit)
            root_reg <= root_reg & ~(map_word_t'(1) << free_r);
    end

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (ctrl.clear_wr)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // Request capture and walk indices
    always_ff @(posedge clk)
    begin
        if (req.valid && ctrl.ready)
            slot_reg <= req.slot_index;
        if (ctrl.root_step)
            r_reg <= fz_idx;
        if (ctrl.mid_step)
            m_reg <= fz_idx;
    end

    // Result capture; a full tree at any level reports no free slot
    always_ff @(posedge clk)
    begin
        if ((ctrl.root_step || ctrl.mid_step) && fz_none)
        begin
            res_granted_reg <= '0;
            res_status_reg  <= ST_FULL;
        end
        else if (ctrl.leaf_step)
        begin
            res_granted_reg <= alloc_ok ? alloc_slot[SLOT_W-1:0] : '0;
            res_status_reg  <= alloc_ok ? ST_OK : ST_FULL;
        end
        else if (ctrl.free_upd)
        begin
            res_granted_reg <= '0;
            res_status_reg  <= free_bad ? ST_BAD_FREE : ST_OK;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_granted_reg <= res_granted_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    assign stat.req_valid  = req.valid;
    assign stat.req_kind   = req.kind;
    assign stat.fz_none    = fz_none;
    assign stat.clear_last = (clr_cnt_reg == WORD_W'(LEAF_DEPTH - 1));
    assign stat.out_free   = !out_valid_reg || rsp.ready;

    hba_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign req.ready         = ctrl.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_index = out_granted_reg;
    assign rsp.status        = out_status_reg;
endmodule
